FILE: rtl/versioned_watch_slot_table_top_assert.svh
`ifndef VERSIONED_WATCH_SLOT_TABLE_TOP_ASSERT_SVH
`define VERSIONED_WATCH_SLOT_TABLE_TOP_ASSERT_SVH

// same-cycle implication
`define VWST_ASSERT_NOW(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("vwst check failed");

// next-cycle implication
`define VWST_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("vwst check failed");

`endif

FILE: rtl/vwst_pkg.sv
`timescale 1ns / 1ps

package vwst_pkg;

  localparam int SLOT_COUNT    = 16;
  localparam int MAX_RECEIVERS = 16;

  localparam int IDX_W = 4;
  localparam int GEN_W = 16;
  localparam int VAL_W = 64;
  localparam int VER_W = 32;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int RCV_W = $clog2(MAX_RECEIVERS + 1);

  typedef enum logic [2:0] {
    CMD_CREATE      = 3'd0,
    CMD_SUBSCRIBE   = 3'd1,
    CMD_DROP_SENDER = 3'd2,
    CMD_DROP_RCV    = 3'd3,
    CMD_SEND        = 3'd4,
    CMD_RECV        = 3'd5,
    CMD_QUERY       = 3'd6,
    CMD_UNDEFINED   = 3'd7
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NOT_FOUND    = 3'd1,
    ST_STALE        = 3'd2,
    ST_DISCONNECTED = 3'd3,
    ST_SENDER_DEAD  = 3'd4,
    ST_EXHAUSTED    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]       command;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] handle_generation;
    logic [VAL_W-1:0] data_value;
    logic [VER_W-1:0] seen_version;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [IDX_W-1:0] out_slot;
    logic [GEN_W-1:0] out_generation;
    logic [VAL_W-1:0] read_value;
    logic [VER_W-1:0] read_version;
    logic             changed;
    logic [4:0]       receiver_total;
    logic             sender_live;
  } rsp_item_t;

endpackage

FILE: rtl/versioned_watch_slot_table_top.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// cmd       in   cmd_valid / cmd_ready  cmd_item_t (command, handle, value, seen version)
// rsp       out  rsp_valid / rsp_ready  rsp_item_t (status, handle, value, version, query)
//
// non-create commands: accept, then an execute step on the slot
// create scans opened slots one per cycle through the shared read port, stopping at the
// first dead slot with no receivers or at the end of the opened slots
// the execute cycle waits while a previous result is still held on rsp
// synchronous reset clears the sequencer, the opened-slot count and all generations

module versioned_watch_slot_table_top
  import vwst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  `include "versioned_watch_slot_table_top_assert.svh"

  state_t state, state_next;

  logic [GEN_W-1:0] slot_generation [SLOT_COUNT];
  logic             slot_sender_alive [SLOT_COUNT];
  logic [VAL_W-1:0] slot_value [SLOT_COUNT];
  logic [VER_W-1:0] slot_version [SLOT_COUNT];
  logic [RCV_W-1:0] slot_receivers [SLOT_COUNT];
  logic [CNT_W-1:0] slots_in_use;

  cmd_item_t        item;
  logic [CNT_W-1:0] scan, scan_next;
  logic [IDX_W-1:0] slot, slot_next;
  logic             exhausted, exhausted_next;
  logic             fresh, fresh_next;

  logic [IDX_W-1:0] addr;
  logic [GEN_W-1:0] gen_rd;
  logic             alive_rd;
  logic [VAL_W-1:0] val_rd;
  logic [VER_W-1:0] ver_rd;
  logic [RCV_W-1:0] rcv_rd;
  logic [GEN_W-1:0] gen_bump;

  logic             out_free;
  logic             rsp_load;
  rsp_item_t        rsp_next;

  logic             we_gen, we_alive, we_val, we_ver, we_rcv, use_inc;
  logic             alive_wr;
  logic [VAL_W-1:0] val_wr;
  logic [VER_W-1:0] ver_wr;
  logic [RCV_W-1:0] rcv_wr;

  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // single read port shared by the scan and the execute step
  assign addr     = (state == S_SCAN) ? scan[IDX_W-1:0] : slot;
  assign gen_rd   = slot_generation[addr];
  assign alive_rd = slot_sender_alive[addr];
  assign val_rd   = slot_value[addr];
  assign ver_rd   = slot_version[addr];
  assign rcv_rd   = slot_receivers[addr];
  assign gen_bump = (gen_rd == {GEN_W{1'b1}}) ? GEN_W'(1) : gen_rd + GEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    scan_next      = scan;
    slot_next      = slot;
    exhausted_next = exhausted;
    fresh_next     = fresh;
    rsp_load       = 1'b0;
    rsp_next       = '0;
    we_gen         = 1'b0;
    we_alive       = 1'b0;
    we_val         = 1'b0;
    we_ver         = 1'b0;
    we_rcv         = 1'b0;
    use_inc        = 1'b0;
    alive_wr       = 1'b0;
    val_wr         = item.data_value;
    ver_wr         = ver_rd + VER_W'(1);
    rcv_wr         = rcv_rd;
    unique case (state)
      S_IDLE: begin
        scan_next      = '0;
        slot_next      = cmd.slot_index;
        exhausted_next = 1'b0;
        fresh_next     = 1'b0;
        if (cmd_valid) begin
          state_next = (cmd.command == CMD_CREATE) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        priority if (scan == slots_in_use) begin
          exhausted_next = (slots_in_use >= CNT_W'(SLOT_COUNT));
          slot_next      = slots_in_use[IDX_W-1:0];
          fresh_next     = 1'b1;
          state_next     = S_EXEC;
        end else if (!alive_rd && rcv_rd == '0) begin
          slot_next  = scan[IDX_W-1:0];
          state_next = S_EXEC;
        end else begin
          scan_next = scan + CNT_W'(1);
        end
      end
      S_EXEC: begin
        if (out_free) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
          priority if (item.command == CMD_CREATE) begin
            if (exhausted) begin
              rsp_next.status = ST_EXHAUSTED;
            end else begin
              we_gen                  = 1'b1;
              we_alive                = 1'b1;
              we_val                  = 1'b1;
              we_ver                  = 1'b1;
              we_rcv                  = 1'b1;
              alive_wr                = 1'b1;
              ver_wr                  = VER_W'(1);
              rcv_wr                  = RCV_W'(1);
              use_inc                 = fresh;
              rsp_next.status         = ST_OK;
              rsp_next.out_slot       = slot;
              rsp_next.out_generation = gen_bump;
            end
          end else if (item.command == CMD_UNDEFINED) begin
            rsp_next.status = ST_NOT_FOUND;
          end else if (CNT_W'(slot) >= slots_in_use) begin
            rsp_next.status = ST_NOT_FOUND;
          end else if (gen_rd != item.handle_generation) begin
            rsp_next.status = ST_STALE;
          end else begin
            rsp_next.status = ST_OK;
            unique case (item.command)
              CMD_SUBSCRIBE: begin
                priority if (!alive_rd) begin
                  rsp_next.status = ST_DISCONNECTED;
                end else if (rcv_rd >= RCV_W'(MAX_RECEIVERS)) begin
                  rsp_next.status = ST_EXHAUSTED;
                end else begin
                  we_rcv                  = 1'b1;
                  rcv_wr                  = rcv_rd + RCV_W'(1);
                  rsp_next.out_slot       = slot;
                  rsp_next.out_generation = gen_rd;
                end
              end
              CMD_DROP_SENDER: begin
                we_alive = 1'b1;
              end
              CMD_DROP_RCV: begin
                if (rcv_rd != '0) begin
                  we_rcv = 1'b1;
                  rcv_wr = rcv_rd - RCV_W'(1);
                end
              end
              CMD_SEND: begin
                if (!alive_rd) begin
                  rsp_next.status = ST_SENDER_DEAD;
                end else begin
                  we_val = 1'b1;
                  we_ver = 1'b1;
                end
              end
              CMD_RECV: begin
                rsp_next.read_value   = val_rd;
                rsp_next.read_version = ver_rd;
              end
              CMD_QUERY: begin
                rsp_next.changed        = (ver_rd != item.seen_version);
                rsp_next.receiver_total = 5'(rcv_rd);
                rsp_next.sender_live    = alive_rd;
              end
              default: begin
                rsp_next.status = ST_NOT_FOUND;
              end
            endcase
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      item <= cmd;
    end
    scan      <= scan_next;
    slot      <= slot_next;
    exhausted <= exhausted_next;
    fresh     <= fresh_next;
  end

  always_ff @(posedge clk) begin
    if (we_alive) begin
      slot_sender_alive[slot] <= alive_wr;
    end
    if (we_val) begin
      slot_value[slot] <= val_wr;
    end
    if (we_ver) begin
      slot_version[slot] <= ver_wr;
    end
    if (we_rcv) begin
      slot_receivers[slot] <= rcv_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_generation[i] <= '0;
      end
      slots_in_use <= '0;
    end else begin
      if (we_gen) begin
        slot_generation[slot] <= gen_bump;
      end
      if (use_inc) begin
        slots_in_use <= slots_in_use + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  `VWST_ASSERT_NOW(a_use_bound, 1'b1, slots_in_use <= CNT_W'(SLOT_COUNT))
  `VWST_ASSERT_NOW(a_scan_bound, state == S_SCAN, scan <= slots_in_use)
  `VWST_ASSERT_NEXT(a_accept_busy, cmd_valid && cmd_ready, state != S_IDLE)
  `VWST_ASSERT_NEXT(a_new_gen_nonzero, we_gen, rsp.out_generation != '0)
  `VWST_ASSERT_NOW(a_open_only_fresh, use_inc, CNT_W'(slot) == slots_in_use)

endmodule

FILE: tb/versioned_watch_slot_table_top_tb.sv
`timescale 1ns / 1ps

module versioned_watch_slot_table_top_tb;
  import vwst_pkg::*;

  localparam int GAP_MAX      = 18;
  localparam int DRAIN_CYCLES = 2 * SLOT_COUNT + 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_ready;
  cmd_item_t cmd = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  versioned_watch_slot_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // shadow copy of the slot table
  logic [GEN_W-1:0] tbl_gen     [SLOT_COUNT];
  logic             tbl_alive   [SLOT_COUNT];
  logic [VAL_W-1:0] tbl_value   [SLOT_COUNT];
  logic [VER_W-1:0] tbl_version [SLOT_COUNT];
  logic [RCV_W-1:0] tbl_rcv     [SLOT_COUNT];
  int               slots_open = 0;

  rsp_item_t pending_rsp [$];
  rsp_item_t last_pred;
  int        errors = 0;
  int        items_sent = 0;
  int        rsp_checked = 0;
  int        cycle_count = 0;
  int        cmd_hist [8];
  bit        burst = 1'b0;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_rsp.size());
      $display("** versioned_watch_slot_table_top: FAILED **");
      $finish;
    end
  end

  function automatic rsp_item_t apply_command(cmd_item_t c);
    rsp_item_t r;
    int pick;
    int idx;
    r = '0;
    idx = int'(c.slot_index);
    if (c.command == CMD_CREATE) begin
      pick = -1;
      for (int i = 0; i < slots_open; i++) begin
        if (pick < 0 && !tbl_alive[i] && tbl_rcv[i] == '0) pick = i;
      end
      if (pick < 0) begin
        if (slots_open >= SLOT_COUNT) begin
          r.status = ST_EXHAUSTED;
          return r;
        end
        pick = slots_open;
        slots_open++;
      end
      tbl_gen[pick] = tbl_gen[pick] + GEN_W'(1);
      if (tbl_gen[pick] == '0) tbl_gen[pick] = GEN_W'(1);
      tbl_alive[pick]   = 1'b1;
      tbl_value[pick]   = c.data_value;
      tbl_version[pick] = VER_W'(1);
      tbl_rcv[pick]     = RCV_W'(1);
      r.status         = ST_OK;
      r.out_slot       = IDX_W'(pick);
      r.out_generation = tbl_gen[pick];
      return r;
    end
    if (c.command == CMD_UNDEFINED || idx >= slots_open) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    if (tbl_gen[idx] != c.handle_generation) begin
      r.status = ST_STALE;
      return r;
    end
    r.status = ST_OK;
    case (c.command)
      CMD_SUBSCRIBE: begin
        if (!tbl_alive[idx]) begin
          r.status = ST_DISCONNECTED;
        end else if (tbl_rcv[idx] >= MAX_RECEIVERS) begin
          r.status = ST_EXHAUSTED;
        end else begin
          tbl_rcv[idx]++;
          r.out_slot       = IDX_W'(idx);
          r.out_generation = tbl_gen[idx];
        end
      end
      CMD_DROP_SENDER: tbl_alive[idx] = 1'b0;
      CMD_DROP_RCV: begin
        if (tbl_rcv[idx] != '0) tbl_rcv[idx]--;
      end
      CMD_SEND: begin
        if (!tbl_alive[idx]) begin
          r.status = ST_SENDER_DEAD;
        end else begin
          tbl_value[idx]   = c.data_value;
          tbl_version[idx] = tbl_version[idx] + VER_W'(1);
        end
      end
      CMD_RECV: begin
        r.read_value   = tbl_value[idx];
        r.read_version = tbl_version[idx];
      end
      default: begin
        r.changed        = (tbl_version[idx] != c.seen_version);
        r.receiver_total = 5'(tbl_rcv[idx]);
        r.sender_live    = tbl_alive[idx];
      end
    endcase
    return r;
  endfunction

  function automatic cmd_item_t make_item(logic [2:0] op, int idx, logic [GEN_W-1:0] gen,
                                          logic [VAL_W-1:0] data, logic [VER_W-1:0] seen);
    cmd_item_t c;
    c.command           = op;
    c.slot_index        = IDX_W'(idx);
    c.handle_generation = gen;
    c.data_value        = data;
    c.seen_version      = seen;
    return c;
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t c;
    int roll;
    int hroll;
    int idx;
    roll = $urandom_range(0, 99);
    if (roll < 14) c.command = CMD_CREATE;
    else if (roll < 30) c.command = CMD_SUBSCRIBE;
    else if (roll < 38) c.command = CMD_DROP_SENDER;
    else if (roll < 50) c.command = CMD_DROP_RCV;
    else if (roll < 70) c.command = CMD_SEND;
    else if (roll < 84) c.command = CMD_RECV;
    else if (roll < 98) c.command = CMD_QUERY;
    else c.command = CMD_UNDEFINED;
    hroll = $urandom_range(0, 99);
    if (slots_open > 0 && hroll < 85) begin
      idx = $urandom_range(0, slots_open - 1);
      c.handle_generation = tbl_gen[idx];
    end else if (slots_open > 0 && hroll < 93) begin
      idx = $urandom_range(0, slots_open - 1);
      c.handle_generation = tbl_gen[idx] + GEN_W'($urandom_range(1, 3));
    end else begin
      idx = $urandom_range(0, SLOT_COUNT - 1);
      c.handle_generation = GEN_W'($urandom);
    end
    c.slot_index = IDX_W'(idx);
    case ($urandom_range(0, 9))
      0: c.data_value = '0;
      1: c.data_value = '1;
      default: c.data_value = {$urandom, $urandom};
    endcase
    c.seen_version = $urandom_range(0, 1) ? tbl_version[idx] : VER_W'($urandom);
    return c;
  endfunction

  task automatic send_item(cmd_item_t c);
    int gap;
    gap = burst ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd = c;
    cmd_valid = 1'b1;
    do @(posedge clk); while (!cmd_ready);
    last_pred = apply_command(c);
    pending_rsp.push_back(last_pred);
    items_sent++;
    cmd_hist[c.command]++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin : rsp_sink
    int stall;
    rsp_item_t want;
    wait (!rst);
    forever begin
      stall = burst ? 0 : $urandom_range(0, GAP_MAX);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result: expected none actual status %0d", $time, rsp.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", want.status, rsp.status);
        check_field("out_slot", want.out_slot, rsp.out_slot);
        check_field("out_generation", want.out_generation, rsp.out_generation);
        check_field("read_value", want.read_value, rsp.read_value);
        check_field("read_version", want.read_version, rsp.read_version);
        check_field("changed", want.changed, rsp.changed);
        check_field("receiver_total", want.receiver_total, rsp.receiver_total);
        check_field("sender_live", want.sender_live, rsp.sender_live);
        rsp_checked++;
      end
    end
  end

  task automatic test_empty_table();
    send_item(make_item(CMD_RECV, 0, '0, '0, '0));
    send_item(make_item(CMD_QUERY, SLOT_COUNT - 1, '1, '1, '1));
    send_item(make_item(CMD_DROP_SENDER, 0, '0, '0, '0));
    send_item(make_item(CMD_UNDEFINED, 3, 16'h1234, '1, '0));
  endtask

  task automatic test_handle_lifecycle();
    int s;
    logic [GEN_W-1:0] g;
    send_item(make_item(CMD_CREATE, 0, '0, '1, '0));
    s = last_pred.out_slot;
    g = last_pred.out_generation;
    send_item(make_item(CMD_RECV, s, g, '0, '0));
    send_item(make_item(CMD_SEND, s, g, '0, '0));
    send_item(make_item(CMD_RECV, s, g, '0, '0));
    send_item(make_item(CMD_QUERY, s, g, '0, VER_W'(2)));
    send_item(make_item(CMD_QUERY, s, g, '0, '0));
    send_item(make_item(CMD_SUBSCRIBE, s, g, '0, '0));
    send_item(make_item(CMD_QUERY, s, g, '0, '1));
    repeat (3) send_item(make_item(CMD_DROP_RCV, s, g, '0, '0));
    send_item(make_item(CMD_SEND, s, g + 1'b1, '1, '0));
    send_item(make_item(CMD_RECV, s, '0, '0, '0));
    send_item(make_item(CMD_RECV, s + 1, g, '0, '0));
    send_item(make_item(CMD_DROP_SENDER, s, g, '0, '0));
    send_item(make_item(CMD_SEND, s, g, 64'h0123_4567_89ab_cdef, '0));
    send_item(make_item(CMD_SUBSCRIBE, s, g, '0, '0));
    send_item(make_item(CMD_QUERY, s, g, '0, VER_W'(2)));
    // dead and unwatched: create takes it back with a new generation
    send_item(make_item(CMD_CREATE, 0, '0, '0, '0));
    send_item(make_item(CMD_RECV, s, g, '0, '0));
    send_item(make_item(CMD_RECV, last_pred.out_slot, last_pred.out_generation, '0, '0));
  endtask

  task automatic test_receiver_limit();
    int s;
    logic [GEN_W-1:0] g;
    send_item(make_item(CMD_CREATE, 0, '0, {$urandom, $urandom}, '0));
    s = last_pred.out_slot;
    g = last_pred.out_generation;
    repeat (MAX_RECEIVERS) send_item(make_item(CMD_SUBSCRIBE, s, g, '0, '0));
    send_item(make_item(CMD_QUERY, s, g, '0, '0));
    repeat (MAX_RECEIVERS + 1) send_item(make_item(CMD_DROP_RCV, s, g, '0, '0));
    send_item(make_item(CMD_QUERY, s, g, '0, VER_W'(1)));
  endtask

  task automatic test_table_exhaustion();
    int tries;
    tries = 0;
    do begin
      send_item(make_item(CMD_CREATE, 0, '0, {$urandom, $urandom}, '0));
      tries++;
    end while (last_pred.status != ST_EXHAUSTED && tries < 2 * SLOT_COUNT);
    send_item(make_item(CMD_CREATE, 0, '0, '1, '0));
  endtask

  task automatic test_slot_reuse();
    int picks [2];
    picks[0] = SLOT_COUNT - 3;
    picks[1] = 2;
    foreach (picks[k]) begin
      send_item(make_item(CMD_DROP_SENDER, picks[k], tbl_gen[picks[k]], '0, '0));
      while (tbl_rcv[picks[k]] != '0) begin
        send_item(make_item(CMD_DROP_RCV, picks[k], tbl_gen[picks[k]], '0, '0));
      end
    end
    repeat (3) send_item(make_item(CMD_CREATE, 0, '0, {$urandom, $urandom}, '0));
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      if (k % 150 == 149) wait_drained();
      send_item(random_item());
    end
    burst = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      tbl_gen[i]     = '0;
      tbl_alive[i]   = 1'b0;
      tbl_value[i]   = '0;
      tbl_version[i] = '0;
      tbl_rcv[i]     = '0;
    end
    foreach (cmd_hist[i]) cmd_hist[i] = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    wait_drained();
    test_handle_lifecycle();
    wait_drained();
    test_receiver_limit();
    wait_drained();
    test_random(600);
    wait_drained();
    test_table_exhaustion();
    wait_drained();
    test_slot_reuse();
    wait_drained();
    test_random(450);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items: %0d create, %0d subscribe, %0d drop sender, %0d drop receiver,",
             items_sent, cmd_hist[CMD_CREATE], cmd_hist[CMD_SUBSCRIBE],
             cmd_hist[CMD_DROP_SENDER], cmd_hist[CMD_DROP_RCV]);
    $display("%0d send, %0d recv, %0d query, %0d undefined; %0d results compared",
             cmd_hist[CMD_SEND], cmd_hist[CMD_RECV], cmd_hist[CMD_QUERY],
             cmd_hist[CMD_UNDEFINED], rsp_checked);
    if (errors == 0) begin
      $display("** versioned_watch_slot_table_top: PASSED **");
    end else begin
      $display("** versioned_watch_slot_table_top: FAILED **");
    end
    $finish;
  end

endmodule
